// File: rtl/gbp_pkg.sv
package gbp_pkg;

    // Width of the number, of the prime addends and of the trial divisor
    localparam int W = 10;

    // Cycle counter width of the remainder unit (counts 0 .. W-1)
    localparam int CNT_W = $clog2(W);

    // Cap on the pairs listed for one number
    localparam int MAX_RESULTS = 40;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_VERDICT,
        S_NEXT,
        S_FINISH
    } t_state;

endpackage

// File: rtl/gbp_rem.sv
// Restoring remainder unit: one quotient bit per cycle.
module gbp_rem
    import gbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_remainder
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_shift, n_shift;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_dsr, n_dsr;
    logic [W:0]       w_trial;

    assign w_trial = {r_rem, r_shift[W-1]};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_shift = i_dividend;
            n_rem   = '0;
            n_dsr   = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_shift = {r_shift[W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = W'(w_trial - {1'b0, r_dsr});
            end else begin
                n_rem = w_trial[W-1:0];
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// File: rtl/goldbach_pair_finder.sv
// Goldbach pair finder. Pulse start with a number while busy is low; the
// block then lists every split number = p + q with p <= q and both prime,
// in order of rising p, one beat per pair on o_strobe, with o_last on the
// final beat. An odd number, or one above MAX_NUMBER, gives a single beat
// with found low and odd_input set to the parity of the number; an even
// number with no split (0 and 2) gives a single beat with found low. Beats
// are shown for exactly one cycle and cannot be stalled, so the receiver
// must take every strobe. Each candidate is tested by trial division through
// one shared remainder unit; for each divisor the unit is loaded, works one
// bit per cycle, and the remainder is then acted on, and each candidate
// adds its own sequencing states. The run time of a number is set by the
// count of candidate and divisor pairs times the remainder unit's time per
// divisor. A single-beat answer for an odd or oversized number appears the
// cycle after acceptance and busy never rises. The pair list stops at
// MAX_RESULTS entries.
module goldbach_pair_finder
    import gbp_pkg::*;
#(
    parameter int MAX_NUMBER = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [W-1:0] i_number,
    output logic         o_strobe,
    output logic [W-1:0] o_smaller_prime,
    output logic [W-1:0] o_larger_prime,
    output logic         o_found,
    output logic         o_odd_input,
    output logic         o_last
);

    t_state r_state, n_state;

    logic [W-1:0]       r_number, n_number;
    logic [W-1:0]       r_p, n_p;          // candidate smaller addend
    logic [W-1:0]       r_val, n_val;      // value under primality test
    logic [W-1:0]       r_div, n_div;      // trial divisor
    logic [W:0]         r_sq, n_sq;        // r_div squared
    logic               r_phase, n_phase;  // low: testing p, high: testing q
    logic               r_prime, n_prime;
    logic               r_pend, n_pend;    // a found pair waits for its last flag
    logic [W-1:0]       r_pend_p, n_pend_p;
    logic [W-1:0]       r_pend_q, n_pend_q;
    logic [COUNT_W-1:0] r_count, n_count;

    logic               r_strobe, n_strobe;
    logic [W-1:0]       r_small, n_small;
    logic [W-1:0]       r_large, n_large;
    logic               r_found, n_found;
    logic               r_odd, n_odd;
    logic               r_last, n_last;

    logic               w_accept;
    logic               w_single;
    logic [W-1:0]       w_half;
    logic [W-1:0]       w_p_inc;
    logic               w_rem_start;
    logic               w_rem_done;
    logic [W-1:0]       w_rem;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_single = i_number[0] || (i_number > W'(MAX_NUMBER));
    assign w_half   = {1'b0, r_number[W-1:1]};
    assign w_p_inc  = r_p + 1'b1;

    gbp_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_rem_start),
        .i_dividend  (r_val),
        .i_divisor   (r_div),
        .o_done      (w_rem_done),
        .o_remainder (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !w_single) begin
                    // p starts at 2; nothing to test when 2 > number/2
                    n_state = (i_number < W'(4)) ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_val < W'(2) || r_sq > {1'b0, r_val}) begin
                    n_state = S_VERDICT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    n_state = (w_rem == '0) ? S_VERDICT : S_CHECK;
                end
            end
            S_VERDICT: begin
                if (r_prime && !r_phase) begin
                    n_state = S_CHECK;
                end else if (r_prime && r_count == COUNT_W'(MAX_RESULTS - 1)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_state = (w_p_inc > w_half) ? S_FINISH : S_CHECK;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and result beats
    always_comb begin
        n_number    = r_number;
        n_p         = r_p;
        n_val       = r_val;
        n_div       = r_div;
        n_sq        = r_sq;
        n_phase     = r_phase;
        n_prime     = r_prime;
        n_pend      = r_pend;
        n_pend_p    = r_pend_p;
        n_pend_q    = r_pend_q;
        n_count     = r_count;
        n_strobe    = 1'b0;
        n_small     = r_small;
        n_large     = r_large;
        n_found     = r_found;
        n_odd       = r_odd;
        n_last      = r_last;
        w_rem_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_number = i_number;
                    n_p      = W'(2);
                    n_val    = W'(2);
                    n_div    = W'(2);
                    n_sq     = (W + 1)'(4);
                    n_phase  = 1'b0;
                    n_pend   = 1'b0;
                    n_count  = '0;
                    if (w_single) begin
                        // drop straight to a single flagged beat
                        n_strobe = 1'b1;
                        n_small  = '0;
                        n_large  = '0;
                        n_found  = 1'b0;
                        n_odd    = i_number[0];
                        n_last   = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (r_val < W'(2)) begin
                    n_prime = 1'b0;
                end else if (r_sq > {1'b0, r_val}) begin
                    n_prime = 1'b1;
                end else begin
                    w_rem_start = 1'b1;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    if (w_rem == '0) begin
                        n_prime = 1'b0;
                    end else begin
                        // advance divisor: (d+1)^2 = d^2 + 2d + 1
                        n_div = r_div + 1'b1;
                        n_sq  = r_sq + {r_div, 1'b1};
                    end
                end
            end
            S_VERDICT: begin
                if (r_prime && !r_phase) begin
                    n_phase = 1'b1;
                    n_val   = r_number - r_p;
                    n_div   = W'(2);
                    n_sq    = (W + 1)'(4);
                end else if (r_prime) begin
                    // flush the previous pair; it is known not to be last
                    if (r_pend) begin
                        n_strobe = 1'b1;
                        n_small  = r_pend_p;
                        n_large  = r_pend_q;
                        n_found  = 1'b1;
                        n_odd    = 1'b0;
                        n_last   = 1'b0;
                    end
                    n_pend   = 1'b1;
                    n_pend_p = r_p;
                    n_pend_q = r_val;
                    n_count  = r_count + 1'b1;
                end
            end
            S_NEXT: begin
                n_p     = w_p_inc;
                n_val   = w_p_inc;
                n_div   = W'(2);
                n_sq    = (W + 1)'(4);
                n_phase = 1'b0;
            end
            S_FINISH: begin
                n_strobe = 1'b1;
                n_odd    = 1'b0;
                n_last   = 1'b1;
                n_found  = r_pend;
                n_small  = r_pend ? r_pend_p : '0;
                n_large  = r_pend ? r_pend_q : '0;
                n_pend   = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend   <= 1'b0;
            r_phase  <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend   <= n_pend;
            r_phase  <= n_phase;
            r_count  <= n_count;
        end
        r_number <= n_number;
        r_p      <= n_p;
        r_val    <= n_val;
        r_div    <= n_div;
        r_sq     <= n_sq;
        r_prime  <= n_prime;
        r_pend_p <= n_pend_p;
        r_pend_q <= n_pend_q;
        r_small  <= n_small;
        r_large  <= n_large;
        r_found  <= n_found;
        r_odd    <= n_odd;
        r_last   <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_smaller_prime = r_small;
    assign o_larger_prime  = r_large;
    assign o_found         = r_found;
    assign o_odd_input     = r_odd;
    assign o_last          = r_last;

    // A pair beat splits the number it was found for, smaller addend first
    a_pair_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |->
            (({1'b0, o_smaller_prime} + {1'b0, o_larger_prime}) == {1'b0, r_number})
            && (o_smaller_prime <= o_larger_prime))
        else $error("pair beat does not split the number");

    // An odd-flagged beat is the only beat of its item and carries no pair
    a_odd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_odd_input) |-> (o_last && !o_found))
        else $error("odd beat malformed");

    // Leaving the busy phase always delivers the closing beat
    a_close_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last))
        else $error("item ended without a last beat");

    // The remainder unit is only started from the test state
    a_rem_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_start |=> (r_state == S_DIV))
        else $error("remainder unit started out of sequence");

endmodule
